/* rtl/nbhd_pkg.sv */
// ----------------------------------------------------------------------------
// nbhd_pkg
// Shared types, constants and helpers for the 9-bit half-duplex queue pair.
// ----------------------------------------------------------------------------
package nbhd_pkg;

  // Default queue depths and reserve register reset value
  localparam int unsigned TxDepthDef   = 32;
  localparam int unsigned RxDepthDef   = 32;
  localparam int unsigned ReserveW     = 6;
  localparam logic [ReserveW-1:0] ReserveReset = 6'd18;

  // Word widths
  localparam int unsigned LineWordW = 9;
  localparam int unsigned ByteW     = 8;

  // Request action codes
  typedef enum logic [2:0] {
    ACT_SEND_DATA = 3'd0,
    ACT_SEND_CALL = 3'd1,
    ACT_TX_SLOT   = 3'd2,
    ACT_RX_BYTE   = 3'd3,
    ACT_TX_DONE   = 3'd4,
    ACT_RX_READ   = 3'd5,
    ACT_RX_FLUSH  = 3'd6
  } action_e;

  // Control from the decoder to one ring queue
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } ring_ctrl_t;

  // Call word: bits 0-6 kept, even parity of them in bit 7, bit 8 set
  function automatic logic [LineWordW-1:0] call_word(input logic [ByteW-1:0] b);
    logic par;
    par = ^b[6:0];
    return {1'b1, par, b[6:0]};
  endfunction

endpackage

/* rtl/nbhd_ring.sv */
// ----------------------------------------------------------------------------
// nbhd_ring
// Ring queue on a synchronous single-write, single-read memory. The head
// entry is read on a pop and appears on rdata_o in the next cycle.
// ----------------------------------------------------------------------------
module nbhd_ring
  import nbhd_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ring_ctrl_t                 ctrl_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [WIDTH-1:0] rdata_q;
  logic             do_push, do_pop;

  // Full drops pushes, empty ignores pops
  assign do_push = ctrl_i.push && (count_q != CntW'(DEPTH));
  assign do_pop  = ctrl_i.pop  && (count_q != '0);

  // Pointer and fill update
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.flush) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (do_push) begin
      tail_d  = (tail_q == PtrW'(DEPTH-1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end else if (do_pop) begin
      head_d  = (head_q == PtrW'(DEPTH-1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Storage: write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[tail_q] <= wdata_i;
    end
    if (do_pop) begin
      rdata_q <= mem[head_q];
    end
  end

  assign rdata_o = rdata_q;
  assign count_o = count_q;

endmodule

/* rtl/nine_bit_half_duplex_fifo_pair_top.sv */
// ----------------------------------------------------------------------------
// nine_bit_half_duplex_fifo_pair_top
// Transmit and receive queues for a half-duplex 9-bit serial bus.
// The result strobe done_o comes in the cycle after start is taken.
// Throughput: one request per cycle; busy stays low, queue state is
// updated at the accepting edge and the popped entry leaves the memory's
// registered read port in the next cycle. Results cannot be stalled.
// Reset clears pointers, fills and direction (receive); reserve reads 18.
// ----------------------------------------------------------------------------
module nine_bit_half_duplex_fifo_pair_top
  import nbhd_pkg::*;
#(
  parameter int unsigned TX_DEPTH = TxDepthDef,
  parameter int unsigned RX_DEPTH = RxDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           action_i,
  input  logic [ByteW-1:0]     data_byte_i,
  input  logic                 frame_error_i,
  // result channel
  output logic                 done_o,
  output logic                 line_word_valid_o,
  output logic [LineWordW-1:0] line_word_o,
  output logic [ByteW-1:0]     read_byte_o,
  output logic                 tx_ready_o,
  output logic                 tx_nearly_full_o,
  output logic                 rx_ready_o,
  output logic                 drive_transmit_o,
  output logic                 overrun_o,
  // configuration channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [ReserveW-1:0]  cfg_data_i
);

  localparam int unsigned TxCntW = $clog2(TX_DEPTH+1);
  localparam int unsigned RxCntW = $clog2(RX_DEPTH+1);
  localparam int unsigned SumW   = ((TxCntW > ReserveW) ? TxCntW : ReserveW) + 1;

  logic                 accept;
  action_e              action;
  ring_ctrl_t           tx_ctrl, rx_ctrl;
  logic [LineWordW-1:0] tx_wdata;
  logic [LineWordW-1:0] tx_rdata;
  logic [ByteW-1:0]     rx_rdata;
  logic [TxCntW-1:0]    tx_count;
  logic [RxCntW-1:0]    rx_count;
  logic                 tx_full, rx_full;
  logic [SumW-1:0]      tx_sum;

  logic                 done_q, lw_valid_q, rd_valid_q, ovr_q, dir_q;
  logic                 lw_valid_d, rd_valid_d, ovr_d, dir_d;
  logic [ReserveW-1:0]  reserve_q;

  // Every request is taken at once, so busy never rises
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign action      = action_e'(action_i);

  assign tx_full = (tx_count == TxCntW'(TX_DEPTH));
  assign rx_full = (rx_count == RxCntW'(RX_DEPTH));

  // Decode request into queue controls and result flags
  always_comb begin
    tx_ctrl    = '0;
    rx_ctrl    = '0;
    tx_wdata   = {1'b0, data_byte_i};
    lw_valid_d = 1'b0;
    rd_valid_d = 1'b0;
    ovr_d      = 1'b0;
    dir_d      = dir_q;
    if (accept) begin
      case (action)
        ACT_SEND_DATA, ACT_SEND_CALL: begin
          tx_ctrl.push = 1'b1;
          if (action == ACT_SEND_CALL) begin
            tx_wdata = call_word(data_byte_i);
          end
          ovr_d = tx_full;
          dir_d = 1'b1;
        end
        ACT_TX_SLOT: begin
          tx_ctrl.pop = 1'b1;
          lw_valid_d  = (tx_count != '0);
        end
        ACT_RX_BYTE: begin
          if (!frame_error_i) begin
            rx_ctrl.push = 1'b1;
            ovr_d        = rx_full;
          end
        end
        ACT_TX_DONE: begin
          dir_d = 1'b0;
        end
        ACT_RX_READ: begin
          rx_ctrl.pop = 1'b1;
          rd_valid_d  = (rx_count != '0);
        end
        ACT_RX_FLUSH: begin
          rx_ctrl.flush = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  nbhd_ring #(
    .DEPTH (TX_DEPTH),
    .WIDTH (LineWordW)
  ) u_tx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (tx_ctrl),
    .wdata_i (tx_wdata),
    .rdata_o (tx_rdata),
    .count_o (tx_count)
  );

  nbhd_ring #(
    .DEPTH (RX_DEPTH),
    .WIDTH (ByteW)
  ) u_rx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rx_ctrl),
    .wdata_i (data_byte_i),
    .rdata_o (rx_rdata),
    .count_o (rx_count)
  );

  // Result strobe, per-request flags, line direction and reserve register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q     <= 1'b0;
      lw_valid_q <= 1'b0;
      rd_valid_q <= 1'b0;
      ovr_q      <= 1'b0;
      dir_q      <= 1'b0;
      reserve_q  <= ReserveReset;
    end else begin
      done_q     <= accept;
      lw_valid_q <= lw_valid_d;
      rd_valid_q <= rd_valid_d;
      ovr_q      <= ovr_d;
      dir_q      <= dir_d;
      if (cfg_valid_i && cfg_ready_o) begin
        reserve_q <= cfg_data_i;
      end
    end
  end

  // Fill flags from the post-request queue state
  assign tx_sum = SumW'(tx_count) + SumW'(reserve_q);

  assign done_o            = done_q;
  assign line_word_valid_o = lw_valid_q;
  assign line_word_o       = lw_valid_q ? tx_rdata : '0;
  assign read_byte_o       = rd_valid_q ? rx_rdata : '0;
  assign tx_ready_o        = (tx_sum < SumW'(TX_DEPTH));
  assign tx_nearly_full_o  = (tx_sum > SumW'(TX_DEPTH));
  assign rx_ready_o        = (rx_count != '0);
  assign drive_transmit_o  = dir_q;
  assign overrun_o         = ovr_q;

endmodule
